// ===== rtl/core/sta_pkg.sv =====
`default_nettype none
package sta_pkg;

   localparam int TERM_CAPACITY_DEF = 64;
   localparam int VAR_COUNT_DEF     = 4096;

   localparam int CMD_W  = 2;
   localparam int VAR_W  = 12;
   localparam int COEF_W = 64;
   localparam int CBITS_W = 7;

   localparam logic [CBITS_W-1:0] COEF_BITS_RESET = 7'd32;

   typedef enum logic [CMD_W-1:0] {
      CMD_ADD   = 2'd0,
      CMD_SUB   = 2'd1,
      CMD_CLEAR = 2'd2,
      CMD_NORM  = 2'd3
   } sta_cmd_type;

   typedef enum logic [3:0] {
      ST_INIT,
      ST_IDLE,
      ST_MUL0,
      ST_MUL1,
      ST_MUL2,
      ST_ACC,
      ST_SCAN,
      ST_PROC,
      ST_SEL,
      ST_PUSH,
      ST_FINAL
   } sta_state_type;

endpackage
`default_nettype wire

// ===== rtl/core/sta_ram.sv =====
`default_nettype none
module sta_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

// ===== rtl/core/sparse_term_accumulator.sv =====
`default_nettype none
// Sparse term accumulator: a table of up to TERM_CAPACITY terms keyed by a
// variable id, with an id-to-slot map held in a memory.
// The request channel (req_valid, req_stall) takes one command beat: accumulate,
// accumulate negated, clear, or normalize and emit. The response channel
// (rsp_valid, rsp_stall) returns the terms of a normalize run in id order, the
// last beat marked by rsp_last; an empty table gives one beat with
// rsp_empty_res set. The csr channel writes the coefficient width at any time
// the block is idle.
// An accumulate steps through MUL0, MUL1, MUL2 and ACC: three passes of a
// shared 32x32 multiplier, with the map read and then the slot read issued
// alongside them, and last a slot read-modify-write; a clear is done in IDLE.
// A normalize scans the term memory once for each term that it picks in id
// order and once more to find none left; the single read port of the term
// memory sets its length. After reset the block runs a clearing pass over all
// VAR_COUNT entries of the map memory with req_stall high. A stalled response
// holds its beat in the output register while the block keeps taking commands;
// a normalize waits there only when it needs the output register again.
module sparse_term_accumulator #(
   parameter int TERM_CAPACITY = sta_pkg::TERM_CAPACITY_DEF,
   parameter int VAR_COUNT     = sta_pkg::VAR_COUNT_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic [sta_pkg::CMD_W-1:0]    req_cmd,
   input  logic [sta_pkg::VAR_W-1:0]    req_var_id,
   input  logic [sta_pkg::COEF_W-1:0]   req_coef_a,
   input  logic [sta_pkg::COEF_W-1:0]   req_coef_b,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic [sta_pkg::VAR_W-1:0]    rsp_out_var,
   output logic [sta_pkg::COEF_W-1:0]   rsp_out_coef,
   output logic                         rsp_negated,
   output logic                         rsp_empty_res,
   output logic                         rsp_overflow,
   output logic                         rsp_last,
   input  logic                         csr_valid,
   output logic                         csr_ready,
   input  logic [sta_pkg::CBITS_W-1:0]  csr_coef_bits
);
   import sta_pkg::*;

   localparam int SLOT_W = $clog2(TERM_CAPACITY);
   localparam int CNT_W  = $clog2(TERM_CAPACITY + 1);
   localparam int MAP_AW = $clog2(VAR_COUNT);
   localparam int TA_W   = SLOT_W + 1;
   localparam int TW_W   = VAR_W + COEF_W;

   function automatic logic [6:0] pop64(input logic [COEF_W-1:0] v);
      logic [6:0] n;
      n = '0;
      for (int i = 0; i < COEF_W; i++) begin
         n = n + 7'(v[i]);
      end
      return n;
   endfunction

   sta_state_type state_ff, state_in;

   logic [CMD_W-1:0]   cmd_ff, cmd_in;
   logic [VAR_W-1:0]   id_ff, id_in;
   logic [COEF_W-1:0]  a_ff, a_in, b_ff, b_in, prod_ff, prod_in;
   logic [COEF_W-1:0]  mask_ff, mask_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               overflow_ff, overflow_in;
   logic               bank_ff, bank_in;
   logic [MAP_AW-1:0]  init_ff, init_in;
   logic [CNT_W-1:0]   scan_ff, scan_in, n_ff, n_in, kept_ff, kept_in;
   logic               rdp_ff, rdp_in, first_ff, first_in, bestv_ff, bestv_in;
   logic [VAR_W-1:0]   prev_ff, prev_in, bvar_ff, bvar_in;
   logic [COEF_W-1:0]  bcoef_ff, bcoef_in, c_ff, c_in, na_ff, na_in;
   logic [VAR_W-1:0]   new_var_ff, new_var_in;
   logic [COEF_W-1:0]  new_coef_ff, new_coef_in;
   logic               new_neg_ff, new_neg_in;
   logic               pend_v_ff, pend_v_in;
   logic [VAR_W-1:0]   pend_var_ff, pend_var_in;
   logic [COEF_W-1:0]  pend_coef_ff, pend_coef_in;
   logic               pend_neg_ff, pend_neg_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [VAR_W-1:0]   o_var_ff, o_var_in;
   logic [COEF_W-1:0]  o_coef_ff, o_coef_in;
   logic               o_neg_ff, o_neg_in, o_empty_ff, o_empty_in;
   logic               o_ovf_ff, o_ovf_in, o_last_ff, o_last_in;

   logic               map_we, map_re;
   logic [MAP_AW-1:0]  map_waddr, map_raddr;
   logic [SLOT_W-1:0]  map_wdata, map_rdata;
   logic               term_we, term_re;
   logic [TA_W-1:0]    term_waddr, term_raddr;
   logic [TW_W-1:0]    term_wdata, term_rdata;

   logic [31:0]        mul_x, mul_y;
   logic [COEF_W-1:0]  mul_p;
   logic               out_free;

   sta_ram #(.WIDTH(SLOT_W), .DEPTH(VAR_COUNT)) u_map (
      .clock   (clock),
      .wr_en   (map_we),
      .wr_addr (map_waddr),
      .wr_data (map_wdata),
      .rd_en   (map_re),
      .rd_addr (map_raddr),
      .rd_data (map_rdata)
   );

   sta_ram #(.WIDTH(TW_W), .DEPTH(2 ** TA_W)) u_term (
      .clock   (clock),
      .wr_en   (term_we),
      .wr_addr (term_waddr),
      .wr_data (term_wdata),
      .rd_en   (term_re),
      .rd_addr (term_raddr),
      .rd_data (term_rdata)
   );

   // One shared 32x32 multiplier builds the low 64 bits of the product in
   // three passes: low*low, then the two cross terms shifted up by 32.
   always_comb begin
      unique case (state_ff)
         ST_MUL1: begin
            mul_x = a_ff[31:0];
            mul_y = b_ff[63:32];
         end
         ST_MUL2: begin
            mul_x = a_ff[63:32];
            mul_y = b_ff[31:0];
         end
         default: begin
            mul_x = a_ff[31:0];
            mul_y = b_ff[31:0];
         end
      endcase
      mul_p = {32'd0, mul_x} * {32'd0, mul_y};
   end

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != ST_IDLE);
   assign csr_ready = 1'b1;

   always_comb begin
      logic [31:0]       id_wide;
      logic [CNT_W-1:0]  slot_ext;
      logic              hit, in_range;
      logic [COEF_W-1:0] amount, masked, val;
      logic              neg;
      logic [VAR_W-1:0]  tvar;
      logic [CBITS_W-1:0] cb;

      state_in     = state_ff;
      cmd_in       = cmd_ff;
      id_in        = id_ff;
      a_in         = a_ff;
      b_in         = b_ff;
      prod_in      = prod_ff;
      mask_in      = mask_ff;
      count_in     = count_ff;
      overflow_in  = overflow_ff;
      bank_in      = bank_ff;
      init_in      = init_ff;
      scan_in      = scan_ff;
      n_in         = n_ff;
      kept_in      = kept_ff;
      rdp_in       = 1'b0;
      first_in     = first_ff;
      bestv_in     = bestv_ff;
      prev_in      = prev_ff;
      bvar_in      = bvar_ff;
      bcoef_in     = bcoef_ff;
      c_in         = c_ff;
      na_in        = na_ff;
      new_var_in   = new_var_ff;
      new_coef_in  = new_coef_ff;
      new_neg_in   = new_neg_ff;
      pend_v_in    = pend_v_ff;
      pend_var_in  = pend_var_ff;
      pend_coef_in = pend_coef_ff;
      pend_neg_in  = pend_neg_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      o_var_in     = o_var_ff;
      o_coef_in    = o_coef_ff;
      o_neg_in     = o_neg_ff;
      o_empty_in   = o_empty_ff;
      o_ovf_in     = o_ovf_ff;
      o_last_in    = o_last_ff;

      map_we     = 1'b0;
      map_waddr  = '0;
      map_wdata  = '0;
      map_re     = 1'b0;
      map_raddr  = '0;
      term_we    = 1'b0;
      term_waddr = '0;
      term_wdata = '0;
      term_re    = 1'b0;
      term_raddr = '0;

      id_wide  = 32'(id_ff);
      in_range = (id_wide < 32'(VAR_COUNT));
      tvar     = term_rdata[TW_W-1:COEF_W];
      slot_ext = CNT_W'(map_rdata);
      hit      = (slot_ext < count_ff) && (tvar == id_ff);
      amount   = (cmd_ff == CMD_SUB) ? (COEF_W'(0) - prod_ff) : prod_ff;
      masked   = bcoef_ff & mask_ff;
      neg      = pop64(na_ff) < pop64(c_ff);
      val      = neg ? na_ff : c_ff;

      if (csr_valid) begin
         cb = (csr_coef_bits == '0) ? CBITS_W'(1) : csr_coef_bits;
         if (cb >= CBITS_W'(COEF_W)) begin
            mask_in = '1;
         end else begin
            mask_in = (COEF_W'(1) << cb) - COEF_W'(1);
         end
      end else begin
         cb = '0;
      end

      unique case (state_ff)
         ST_INIT: begin
            map_we    = 1'b1;
            map_waddr = init_ff;
            init_in   = init_ff + MAP_AW'(1);
            if (init_ff == MAP_AW'(VAR_COUNT - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               cmd_in = req_cmd;
               id_in  = req_var_id;
               a_in   = req_coef_a;
               b_in   = req_coef_b;
               unique case (req_cmd)
                  CMD_ADD, CMD_SUB: state_in = ST_MUL0;
                  CMD_CLEAR: begin
                     count_in    = '0;
                     overflow_in = 1'b0;
                  end
                  CMD_NORM: begin
                     scan_in  = '0;
                     n_in     = count_ff;
                     first_in = 1'b1;
                     bestv_in = 1'b0;
                     kept_in  = '0;
                     pend_v_in = 1'b0;
                     state_in = ST_SCAN;
                  end
                  default: state_in = ST_IDLE;
               endcase
            end
         end
         ST_MUL0: begin
            map_re    = 1'b1;
            map_raddr = id_wide[MAP_AW-1:0];
            prod_in   = mul_p;
            state_in  = ST_MUL1;
         end
         ST_MUL1: begin
            term_re    = 1'b1;
            term_raddr = {bank_ff, map_rdata};
            prod_in    = prod_ff + {mul_p[31:0], 32'd0};
            state_in   = ST_MUL2;
         end
         ST_MUL2: begin
            prod_in  = prod_ff + {mul_p[31:0], 32'd0};
            state_in = ST_ACC;
         end
         ST_ACC: begin
            state_in = ST_IDLE;
            if (in_range) begin
               if (hit) begin
                  term_we    = 1'b1;
                  term_waddr = {bank_ff, map_rdata};
                  term_wdata = {id_ff, term_rdata[COEF_W-1:0] + amount};
               end else if (count_ff >= CNT_W'(TERM_CAPACITY)) begin
                  overflow_in = 1'b1;
               end else begin
                  term_we    = 1'b1;
                  term_waddr = {bank_ff, count_ff[SLOT_W-1:0]};
                  term_wdata = {id_ff, amount};
                  map_we     = 1'b1;
                  map_waddr  = id_wide[MAP_AW-1:0];
                  map_wdata  = count_ff[SLOT_W-1:0];
                  count_in   = count_ff + CNT_W'(1);
               end
            end
         end
         ST_SCAN: begin
            // Find the smallest id above the last one taken: reads go out
            // one per cycle, and each is compared in the cycle after it goes out.
            if (scan_ff < n_ff) begin
               term_re    = 1'b1;
               term_raddr = {bank_ff, scan_ff[SLOT_W-1:0]};
               scan_in    = scan_ff + CNT_W'(1);
               rdp_in     = 1'b1;
            end
            if (rdp_ff) begin
               if ((first_ff || tvar > prev_ff) && (!bestv_ff || tvar < bvar_ff)) begin
                  bestv_in = 1'b1;
                  bvar_in  = tvar;
                  bcoef_in = term_rdata[COEF_W-1:0];
               end
            end else if (scan_ff == n_ff) begin
               state_in = bestv_ff ? ST_PROC : ST_FINAL;
            end
         end
         ST_PROC: begin
            if (masked == '0) begin
               prev_in  = bvar_ff;
               first_in = 1'b0;
               scan_in  = '0;
               bestv_in = 1'b0;
               state_in = ST_SCAN;
            end else begin
               c_in     = masked;
               na_in    = (COEF_W'(0) - masked) & mask_ff;
               state_in = ST_SEL;
            end
         end
         ST_SEL: begin
            id_wide     = 32'(bvar_ff);
            term_we     = 1'b1;
            term_waddr  = {~bank_ff, kept_ff[SLOT_W-1:0]};
            term_wdata  = {bvar_ff, val};
            map_we      = 1'b1;
            map_waddr   = id_wide[MAP_AW-1:0];
            map_wdata   = kept_ff[SLOT_W-1:0];
            kept_in     = kept_ff + CNT_W'(1);
            new_var_in  = bvar_ff;
            new_coef_in = val;
            new_neg_in  = neg;
            state_in    = ST_PUSH;
         end
         ST_PUSH: begin
            // The newest term is held back one step so that the final
            // beat of the run can carry the last marker.
            if (!pend_v_ff || out_free) begin
               if (pend_v_ff) begin
                  rsp_valid_in = 1'b1;
                  o_var_in     = pend_var_ff;
                  o_coef_in    = pend_coef_ff;
                  o_neg_in     = pend_neg_ff;
                  o_empty_in   = 1'b0;
                  o_ovf_in     = overflow_ff;
                  o_last_in    = 1'b0;
               end
               pend_v_in    = 1'b1;
               pend_var_in  = new_var_ff;
               pend_coef_in = new_coef_ff;
               pend_neg_in  = new_neg_ff;
               prev_in      = bvar_ff;
               first_in     = 1'b0;
               scan_in      = '0;
               bestv_in     = 1'b0;
               state_in     = ST_SCAN;
            end
         end
         ST_FINAL: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               o_var_in     = pend_v_ff ? pend_var_ff : '0;
               o_coef_in    = pend_v_ff ? pend_coef_ff : '0;
               o_neg_in     = pend_v_ff && pend_neg_ff;
               o_empty_in   = !pend_v_ff;
               o_ovf_in     = overflow_ff;
               o_last_in    = 1'b1;
               pend_v_in    = 1'b0;
               count_in     = kept_ff;
               bank_in      = ~bank_ff;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_INIT;
         mask_ff      <= (COEF_W'(1) << COEF_BITS_RESET) - COEF_W'(1);
         count_ff     <= '0;
         overflow_ff  <= 1'b0;
         bank_ff      <= 1'b0;
         init_ff      <= '0;
         rdp_ff       <= 1'b0;
         bestv_ff     <= 1'b0;
         pend_v_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         mask_ff      <= mask_in;
         count_ff     <= count_in;
         overflow_ff  <= overflow_in;
         bank_ff      <= bank_in;
         init_ff      <= init_in;
         rdp_ff       <= rdp_in;
         bestv_ff     <= bestv_in;
         pend_v_ff    <= pend_v_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff       <= cmd_in;
      id_ff        <= id_in;
      a_ff         <= a_in;
      b_ff         <= b_in;
      prod_ff      <= prod_in;
      scan_ff      <= scan_in;
      n_ff         <= n_in;
      kept_ff      <= kept_in;
      first_ff     <= first_in;
      prev_ff      <= prev_in;
      bvar_ff      <= bvar_in;
      bcoef_ff     <= bcoef_in;
      c_ff         <= c_in;
      na_ff        <= na_in;
      new_var_ff   <= new_var_in;
      new_coef_ff  <= new_coef_in;
      new_neg_ff   <= new_neg_in;
      pend_var_ff  <= pend_var_in;
      pend_coef_ff <= pend_coef_in;
      pend_neg_ff  <= pend_neg_in;
      o_var_ff     <= o_var_in;
      o_coef_ff    <= o_coef_in;
      o_neg_ff     <= o_neg_in;
      o_empty_ff   <= o_empty_in;
      o_ovf_ff     <= o_ovf_in;
      o_last_ff    <= o_last_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_out_var   = o_var_ff;
   assign rsp_out_coef  = o_coef_ff;
   assign rsp_negated   = o_neg_ff;
   assign rsp_empty_res = o_empty_ff;
   assign rsp_overflow  = o_ovf_ff;
   assign rsp_last      = o_last_ff;

`ifndef ASSERT_OFF
   a_count_cap: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(TERM_CAPACITY))
      else $error("term count beyond capacity");

   a_ovf_full: assert property (@(posedge clock) disable iff (reset)
      $rose(overflow_ff) |-> count_ff == CNT_W'(TERM_CAPACITY))
      else $error("overflow set with room in the table");

   a_kept_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_SEL |-> kept_ff < n_ff)
      else $error("normalize keeps more terms than it scanned");

   a_proc_best: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_PROC |-> bestv_ff)
      else $error("normalize step without a selected term");
`endif

endmodule
`default_nettype wire

// ===== tb/sparse_term_accumulator_checker.sv =====
`default_nettype none
// Watches the request, response and csr channels, keeps its own copy of the
// term table, and compares every response beat against the expected beats.
module sparse_term_accumulator_checker (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   input  logic                         req_stall,
   input  logic [sta_pkg::CMD_W-1:0]    req_cmd,
   input  logic [sta_pkg::VAR_W-1:0]    req_var_id,
   input  logic [sta_pkg::COEF_W-1:0]   req_coef_a,
   input  logic [sta_pkg::COEF_W-1:0]   req_coef_b,
   input  logic                         rsp_valid,
   input  logic                         rsp_stall,
   input  logic [sta_pkg::VAR_W-1:0]    rsp_out_var,
   input  logic [sta_pkg::COEF_W-1:0]   rsp_out_coef,
   input  logic                         rsp_negated,
   input  logic                         rsp_empty_res,
   input  logic                         rsp_overflow,
   input  logic                         rsp_last,
   input  logic                         csr_valid,
   input  logic                         csr_ready,
   input  logic [sta_pkg::CBITS_W-1:0]  csr_coef_bits,
   output int                           fail_count,
   output int                           pending_beats
);
   import sta_pkg::*;

   localparam int CAP  = TERM_CAPACITY_DEF;
   localparam int NVAR = VAR_COUNT_DEF;

   typedef struct packed {
      logic [VAR_W-1:0]  var_id;
      logic [COEF_W-1:0] coef;
      logic              negated;
      logic              empty_res;
      logic              overflow;
      logic              last;
   } term_beat_type;

   term_beat_type expected_beats[$];

   logic [CBITS_W-1:0] width_reg;
   bit                 id_mapped[NVAR];
   int                 id_slot[NVAR];
   logic [VAR_W-1:0]   slot_var[CAP];
   logic [COEF_W-1:0]  slot_coef[CAP];
   int                 live_terms;
   bit                 dropped_term;

   assign pending_beats = expected_beats.size();

   function automatic logic [COEF_W-1:0] coef_mask();
      int b;
      b = width_reg;
      if (b == 0) b = 1;
      if (b >= 64) return '1;
      return (64'd1 << b) - 64'd1;
   endfunction

   task automatic add_to_term(input logic [VAR_W-1:0] id, input logic [COEF_W-1:0] amount);
      if (id_mapped[id]) begin
         slot_coef[id_slot[id]] += amount;
      end else if (live_terms >= CAP) begin
         dropped_term = 1;
      end else begin
         slot_var[live_terms]  = id;
         slot_coef[live_terms] = amount;
         id_slot[id]   = live_terms;
         id_mapped[id] = 1;
         live_terms++;
      end
   endtask

   task automatic normalize_and_emit();
      logic [VAR_W-1:0]  v;
      logic [COEF_W-1:0] c, m, nc;
      term_beat_type     beat;
      int                kept, j;
      m = coef_mask();
      for (int i = 1; i < live_terms; i++) begin
         v = slot_var[i];
         c = slot_coef[i];
         j = i;
         while (j > 0 && slot_var[j-1] > v) begin
            slot_var[j]  = slot_var[j-1];
            slot_coef[j] = slot_coef[j-1];
            j--;
         end
         slot_var[j]  = v;
         slot_coef[j] = c;
      end
      kept = 0;
      for (int i = 0; i < live_terms; i++) begin
         c = slot_coef[i] & m;
         if (c == 0) begin
            id_mapped[slot_var[i]] = 0;
         end else begin
            slot_var[kept]  = slot_var[i];
            slot_coef[kept] = c;
            id_slot[slot_var[i]] = kept;
            kept++;
         end
      end
      live_terms = kept;
      if (kept == 0) begin
         beat = '{default: '0};
         beat.empty_res = 1;
         beat.last      = 1;
         beat.overflow  = dropped_term;
         expected_beats.push_back(beat);
      end
      for (int i = 0; i < kept; i++) begin
         c  = slot_coef[i];
         nc = (64'd0 - c) & m;
         beat = '{default: '0};
         beat.var_id = slot_var[i];
         if ($countones(nc) < $countones(c)) begin
            slot_coef[i] = nc;
            beat.negated = 1;
         end
         beat.coef     = slot_coef[i];
         beat.overflow = dropped_term;
         beat.last     = (i == kept - 1);
         expected_beats.push_back(beat);
      end
   endtask

   task automatic compare_field(input string name, input logic [63:0] want,
                                input logic [63:0] got);
      if (want !== got) begin
         $error("%s: expected %0h, got %0h", name, want, got);
         fail_count++;
      end
   endtask

   initial fail_count = 0;

   always @(posedge clock) begin
      term_beat_type want;
      if (reset) begin
         width_reg    = COEF_BITS_RESET;
         live_terms   = 0;
         dropped_term = 0;
         foreach (id_mapped[i]) id_mapped[i] = 0;
         expected_beats.delete();
      end else begin
         if (csr_valid && csr_ready) width_reg = csr_coef_bits;
         if (rsp_valid && !rsp_stall) begin
            if (expected_beats.size() == 0) begin
               $error("response beat with no expected beat, var %0d", rsp_out_var);
               fail_count++;
            end else begin
               want = expected_beats.pop_front();
               compare_field("out_var", want.var_id, rsp_out_var);
               compare_field("out_coef", want.coef, rsp_out_coef);
               compare_field("negated", want.negated, rsp_negated);
               compare_field("empty_res", want.empty_res, rsp_empty_res);
               compare_field("overflow", want.overflow, rsp_overflow);
               compare_field("last", want.last, rsp_last);
            end
         end
         if (req_valid && !req_stall) begin
            case (sta_cmd_type'(req_cmd))
               CMD_ADD:   add_to_term(req_var_id, req_coef_a * req_coef_b);
               CMD_SUB:   add_to_term(req_var_id, 64'd0 - req_coef_a * req_coef_b);
               CMD_CLEAR: begin
                  for (int i = 0; i < live_terms; i++) id_mapped[slot_var[i]] = 0;
                  live_terms   = 0;
                  dropped_term = 0;
               end
               default:   normalize_and_emit();
            endcase
         end
      end
   end

endmodule
`default_nettype wire

// ===== tb/sparse_term_accumulator_tb.sv =====
`default_nettype none
// Top of the testbench. It resets the block once, then drives a directed
// sequence followed by random phases with different amounts of idling on both
// sides. The checker beside the block does all prediction and comparison; this
// module only produces stimulus and reports the verdict.
module sparse_term_accumulator_tb;
   import sta_pkg::*;

   logic                clock = 0;
   logic                reset = 1;
   logic                req_valid = 0;
   logic                req_stall;
   logic [CMD_W-1:0]    req_cmd = CMD_ADD;
   logic [VAR_W-1:0]    req_var_id = '0;
   logic [COEF_W-1:0]   req_coef_a = '0;
   logic [COEF_W-1:0]   req_coef_b = '0;
   logic                rsp_valid;
   logic                rsp_stall = 0;
   logic [VAR_W-1:0]    rsp_out_var;
   logic [COEF_W-1:0]   rsp_out_coef;
   logic                rsp_negated, rsp_empty_res, rsp_overflow, rsp_last;
   logic                csr_valid = 0;
   logic                csr_ready;
   logic [CBITS_W-1:0]  csr_coef_bits = '0;
   int                  fail_count, pending_beats;

   // Percent chances of idling; the stimulus changes them phase by phase.
   int sender_idle_pct   = 0;
   int receiver_stall_pct = 0;
   // While set, the receiver stalls without a break so the block backs up.
   bit hold_receiver = 0;

   always #5 clock = ~clock;

   sparse_term_accumulator uut (.*);
   sparse_term_accumulator_checker checker_i (.*);

   // The receiver decides its stall once per cycle, at the falling edge.
   always @(negedge clock) begin
      rsp_stall <= hold_receiver || ($urandom_range(99) < receiver_stall_pct);
   end

   // Offers one request beat and holds it steady until the block takes it.
   // It returns at the falling edge after the beat was taken with req_valid
   // still high, so the caller either offers the next beat or drops req_valid
   // at that same edge.
   task automatic send_beat(input sta_cmd_type cmd, input logic [VAR_W-1:0] id,
                            input logic [COEF_W-1:0] a, input logic [COEF_W-1:0] b);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_valid <= 0;
         @(negedge clock);
      end
      req_valid  <= 1;
      req_cmd    <= cmd;
      req_var_id <= id;
      req_coef_a <= a;
      req_coef_b <= b;
      do @(posedge clock); while (req_stall);
      @(negedge clock);
   endtask

   // Lets all expected beats drain, then a margin for a trailing accumulate.
   task automatic wait_idle();
      req_valid <= 0;
      while (pending_beats != 0) @(negedge clock);
      repeat (20) @(negedge clock);
   endtask

   task automatic write_width(input logic [CBITS_W-1:0] bits);
      wait_idle();
      csr_valid     <= 1;
      csr_coef_bits <= bits;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 0;
   endtask

   function automatic logic [63:0] rand64();
      return {$urandom(), $urandom()};
   endfunction

   // Mostly small sets of ids drawn from a narrow window so that terms repeat,
   // cancel and get normalized; now and then a clear or a stray id.
   task automatic random_phase(input int beats, input int id_base);
      int            r;
      logic [63:0]   a, b;
      for (int n = 0; n < beats; n++) begin
         r = $urandom_range(99);
         case ($urandom_range(3))
            0: a = 64'd1;
            1: a = 64'($urandom_range(7));
            2: a = {$urandom(), $urandom()} >> $urandom_range(63);
            default: a = rand64();
         endcase
         b = ($urandom_range(1) != 0) ? 64'd1 : rand64();
         if (r < 12)
            send_beat(CMD_NORM, 0, rand64(), rand64());
         else if (r < 15)
            send_beat(CMD_CLEAR, VAR_W'(rand64()), rand64(), rand64());
         else if (r < 20)
            send_beat(sta_cmd_type'($urandom_range(1)), VAR_W'($urandom()), a, b);
         else
            send_beat(sta_cmd_type'($urandom_range(1)),
                      VAR_W'((id_base + $urandom_range(11)) % 4096), a, b);
      end
      send_beat(CMD_NORM, 0, 0, 0);
   endtask

   initial begin
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 0;

      // Directed part: extremes of the fields, every command and the special
      // cases such as an empty normalize, cancellation and width extremes.
      send_beat(CMD_NORM, 0, 0, 0);
      send_beat(CMD_ADD, 12'hFFF, '1, '1);
      send_beat(CMD_ADD, 0, 64'h8000_0000_0000_0000, 1);
      send_beat(CMD_SUB, 5, 3, 1);
      send_beat(CMD_ADD, 9, 64'h1_0000_0000, 1);
      send_beat(CMD_ADD, 7, 2, 3);
      send_beat(CMD_SUB, 7, 6, 1);
      send_beat(CMD_NORM, 12'hFFF, '1, '1);
      send_beat(CMD_ADD, 5, 1, 1);
      send_beat(CMD_NORM, 0, 0, 0);
      write_width(64);
      send_beat(CMD_ADD, 12'hABC, '1, 1);
      send_beat(CMD_NORM, 0, 0, 0);
      write_width(0);
      send_beat(CMD_ADD, 1, 1, 1);
      send_beat(CMD_NORM, 0, 0, 0);
      write_width(127);
      send_beat(CMD_NORM, 0, 0, 0);
      // Fill the table past capacity so a new id is dropped and overflow sets.
      for (int i = 0; i < 66; i++) send_beat(CMD_ADD, VAR_W'(i * 61), COEF_W'(i + 1), 64'd1);
      send_beat(CMD_NORM, 0, 0, 0);
      send_beat(CMD_CLEAR, 0, 0, 0);
      send_beat(CMD_NORM, 0, 0, 0);
      write_width(1);
      send_beat(CMD_ADD, 3, 3, 1);
      send_beat(CMD_NORM, 0, 0, 0);
      write_width(32);

      // Long hold-off on the receiver while requests keep coming.
      fork
         begin
            hold_receiver = 1;
            repeat (3000) @(negedge clock);
            hold_receiver = 0;
         end
         begin
            for (int k = 0; k < 4; k++) begin
               send_beat(CMD_ADD, VAR_W'(k), COEF_W'(k + 1), 64'd1);
               send_beat(CMD_NORM, 0, 0, 0);
            end
            req_valid <= 0;
         end
      join

      random_phase(12, 100);
      write_width(8);
      sender_idle_pct = 80;
      random_phase(10, 4080);
      write_width(17);
      sender_idle_pct = 0;
      receiver_stall_pct = 80;
      random_phase(10, 2000);
      write_width(63);
      sender_idle_pct = 16;
      receiver_stall_pct = 16;
      random_phase(12, 300);
      write_width(CBITS_W'($urandom_range(127)));
      random_phase(7, 50);

      wait_idle();
      repeat (200) @(negedge clock);
      if (fail_count == 0 && pending_beats == 0)
         $display("PASS sparse_term_accumulator");
      else
         $display("FAIL sparse_term_accumulator");
      $finish;
   end

   // Hard limit on the run time in case the block hangs.
   initial begin
      #50_000_000;
      $display("FAIL sparse_term_accumulator");
      $finish;
   end

endmodule
`default_nettype wire
